// ===== hw/rtl/tmd_pkg.sv =====
// ----------------------------------------------------------------------------
// tmd_pkg
// Shared constants and types of the truncated-mean dE/dx block.
// ----------------------------------------------------------------------------
`default_nettype none

package tmd_pkg;

    localparam int MAX_SAMPLES  = 64;
    localparam int SAMPLE_W     = 16;
    localparam int ADDR_W       = $clog2(MAX_SAMPLES);
    localparam int CNT_W        = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W        = SAMPLE_W + ADDR_W;
    localparam int DIV_CNT_W    = $clog2(SUM_W + 1);

    localparam int RAW_W        = 8;
    localparam int TENTHS_W     = 4;
    localparam int MIN_W        = 7;
    localparam int PROD_W       = CNT_W + TENTHS_W;

    localparam logic [RAW_W-1:0]    RAW_MAX    = 8'd255;
    localparam logic [TENTHS_W-1:0] TENTHS_MAX = 4'd10;
    localparam logic [TENTHS_W-1:0] TENTHS_RST = 4'd7;
    localparam logic [MIN_W-1:0]    MIN_RST    = 7'd5;

    // floor(x / 10) as (x * 6554) >> 16, exact for x below 2^12
    localparam int RECIP_W      = 13;
    localparam logic [RECIP_W-1:0] RECIP_10 = 13'd6554;
    localparam int RECIP_SHIFT  = 16;

    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;
    localparam logic REG_KEEP_TENTHS = 1'b0;
    localparam logic REG_MIN_KEPT    = 1'b1;

    typedef struct packed {
        logic                we;
        logic [ADDR_W-1:0]   waddr;
        logic [SAMPLE_W-1:0] wdata;
        logic [ADDR_W-1:0]   raddr;
    } t_mem_req;

endpackage

`default_nettype wire

// ===== hw/rtl/truncated_mean_dedx_top.sv =====
// ----------------------------------------------------------------------------
// truncated_mean_dedx_top
// Truncated-mean energy loss of one track, fed one hit per beat.
//
// Input beat: taken when start is high and busy is low. A hit with a
// non-zero sample inserts it, while the store is not full, into the sorted
// store by walking down from the top, one entry examined at a time through
// the single store read port; busy stays high until it is placed.
// Other hits leave busy low unless they carry i_last_hit.
// On the beat with i_last_hit the block finishes the track: it computes
// k = floor(n*tenths/10) in S_MUL and S_KEEP, checks it in S_CHK, sums the k
// smallest samples through the read port, then runs the bit-serial divider.
// Without a valid mean the result is given from the check state.
// Result beat: o_done is high for exactly one cycle with o_raw_hits,
// o_mean_dedx, o_mean_valid and o_store_overflow; the receiver cannot stall.
// Registers over APB: keep_tenths at 0x0, min_kept at 0x4; pready is always
// high. Write them only while idle.
// Reset: synchronous; clears the counters and restores register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module truncated_mean_dedx_top
    import tmd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output      logic                  busy,
    input  wire logic                  i_hit_present,
    input  wire logic [SAMPLE_W-1:0]   i_dedx_sample,
    input  wire logic                  i_last_hit,
    output      logic                  o_done,
    output      logic [RAW_W-1:0]      o_raw_hits,
    output      logic [SAMPLE_W-1:0]   o_mean_dedx,
    output      logic                  o_mean_valid,
    output      logic                  o_store_overflow,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output      logic [APB_DATA_W-1:0] prdata,
    output      logic                  pready
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS,
        S_INS_W,
        S_MUL,
        S_KEEP,
        S_CHK,
        S_SUM,
        S_ACC,
        S_DIV
    } t_state;

    localparam int CMP_W = (CNT_W > MIN_W) ? CNT_W : MIN_W;
    localparam int FULL_W = PROD_W + RECIP_W;

    t_state                r_state;
    logic [TENTHS_W-1:0]   r_keep_tenths;
    logic [MIN_W-1:0]      r_min_kept;
    logic [SAMPLE_W-1:0]   r_sample;
    logic                  r_last;
    logic [CNT_W-1:0]      r_pos;
    logic [CNT_W-1:0]      r_count;
    logic [RAW_W-1:0]      r_raw;
    logic                  r_ovf;
    logic [PROD_W-1:0]     r_prod;
    logic [CNT_W-1:0]      r_kept;
    logic [CNT_W-1:0]      r_idx;
    logic [SUM_W-1:0]      r_sum;

    t_mem_req              mem_req;
    logic [SAMPLE_W-1:0]   rdata;
    logic [CNT_W-1:0]      pos_m1;
    logic                  accept;
    logic                  cfg_wr;
    logic [TENTHS_W-1:0]   tenths;
    logic [FULL_W-1:0]     full_prod;
    logic                  div_start;
    logic                  div_done;
    logic [SUM_W-1:0]      quotient;

    assign accept    = start && !busy;
    assign busy      = r_state != S_IDLE;
    assign pos_m1    = r_pos - 1'b1;
    assign tenths    = (r_keep_tenths > TENTHS_MAX) ? TENTHS_MAX : r_keep_tenths;
    assign full_prod = FULL_W'(r_prod) * FULL_W'(RECIP_10);
    assign div_start = (r_state == S_SUM) && (r_idx == r_kept);
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_comb begin
        prdata = '0;
        case (paddr[2])
            REG_KEEP_TENTHS: prdata = APB_DATA_W'(r_keep_tenths);
            REG_MIN_KEPT:    prdata = APB_DATA_W'(r_min_kept);
            default:         prdata = '0;
        endcase
    end

    always_comb begin
        mem_req.we    = 1'b0;
        mem_req.waddr = r_pos[ADDR_W-1:0];
        mem_req.wdata = r_sample;
        mem_req.raddr = pos_m1[ADDR_W-1:0];
        case (r_state)
            S_INS: begin
                if (r_pos == '0) begin
                    mem_req.we = 1'b1;
                end
            end
            S_INS_W: begin
                mem_req.we    = 1'b1;
                mem_req.wdata = (rdata > r_sample) ? rdata : r_sample;
            end
            S_SUM: begin
                mem_req.raddr = r_idx[ADDR_W-1:0];
            end
            default: begin
                mem_req.we = 1'b0;
            end
        endcase
    end

    tmd_store u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (rdata)
    );

    tmd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_kept),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep_tenths <= TENTHS_RST;
            r_min_kept    <= MIN_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_KEEP_TENTHS: r_keep_tenths <= pwdata[TENTHS_W-1:0];
                REG_MIN_KEPT:    r_min_kept    <= pwdata[MIN_W-1:0];
                default:         r_min_kept    <= r_min_kept;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_raw   <= '0;
            r_ovf   <= 1'b0;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_sample <= i_dedx_sample;
                        r_last   <= i_last_hit;
                        r_pos    <= r_count;
                        if (i_hit_present && r_raw != RAW_MAX) begin
                            r_raw <= r_raw + 1'b1;
                        end
                        if (i_hit_present && i_dedx_sample != '0
                            && r_count != CNT_W'(MAX_SAMPLES)) begin
                            r_state <= S_INS;
                        end else begin
                            if (i_hit_present && i_dedx_sample != '0) begin
                                r_ovf <= 1'b1;
                            end
                            if (i_last_hit) begin
                                r_state <= S_MUL;
                            end
                        end
                    end
                end
                S_INS: begin
                    if (r_pos == '0) begin
                        r_count <= r_count + 1'b1;
                        r_state <= r_last ? S_MUL : S_IDLE;
                    end else begin
                        r_state <= S_INS_W;
                    end
                end
                S_INS_W: begin
                    if (rdata > r_sample) begin
                        r_pos   <= pos_m1;
                        r_state <= S_INS;
                    end else begin
                        r_count <= r_count + 1'b1;
                        r_state <= r_last ? S_MUL : S_IDLE;
                    end
                end
                S_MUL: begin
                    r_prod  <= PROD_W'(r_count) * PROD_W'(tenths);
                    r_state <= S_KEEP;
                end
                S_KEEP: begin
                    r_kept  <= CNT_W'(full_prod >> RECIP_SHIFT);
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    r_idx <= '0;
                    r_sum <= '0;
                    if (CMP_W'(r_kept) > CMP_W'(r_min_kept)) begin
                        r_state <= S_SUM;
                    end else begin
                        o_done           <= 1'b1;
                        o_raw_hits       <= r_raw;
                        o_mean_dedx      <= '0;
                        o_mean_valid     <= 1'b0;
                        o_store_overflow <= r_ovf;
                        r_count          <= '0;
                        r_raw            <= '0;
                        r_ovf            <= 1'b0;
                        r_state          <= S_IDLE;
                    end
                end
                S_SUM: begin
                    if (r_idx == r_kept) begin
                        r_state <= S_DIV;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_sum   <= r_sum + SUM_W'(rdata);
                    r_state <= S_SUM;
                end
                S_DIV: begin
                    if (div_done) begin
                        o_done           <= 1'b1;
                        o_raw_hits       <= r_raw;
                        o_mean_dedx      <= quotient[SAMPLE_W-1:0];
                        o_mean_valid     <= 1'b1;
                        o_store_overflow <= r_ovf;
                        r_count          <= '0;
                        r_raw            <= '0;
                        r_ovf            <= 1'b0;
                        r_state          <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_SAMPLES))
        else $error("sample count beyond store depth");

    a_done_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result beats back to back");

    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_last_hit) |=> busy)
        else $error("last hit did not start track finish");

    a_div_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside its phase");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/tmd_store.sv =====
// ----------------------------------------------------------------------------
// tmd_store
// Sample store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tmd_store
    import tmd_pkg::*;
(
    input  wire logic                i_clk,
    input  wire t_mem_req            i_req,
    output      logic [SAMPLE_W-1:0] o_rdata
);

    logic [SAMPLE_W-1:0] r_mem [MAX_SAMPLES];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tmd_div.sv =====
// ----------------------------------------------------------------------------
// tmd_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tmd_div
    import tmd_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [SUM_W-1:0] i_dividend,
    input  wire logic [CNT_W-1:0] i_divisor,
    output      logic             o_done,
    output      logic [SUM_W-1:0] o_quotient
);

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0]     r_rem;
    logic [CNT_W-1:0]     r_div;
    logic [SUM_W-1:0]     r_quo;
    logic [CNT_W:0]       shifted;
    logic                 fits;

    assign shifted    = {r_rem, r_quo[SUM_W-1]};
    assign fits       = shifted >= {1'b0, r_div};
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(SUM_W);
                r_rem  <= '0;
                r_div  <= i_divisor;
                r_quo  <= i_dividend;
            end else if (r_busy) begin
                if (fits) begin
                    r_rem <= CNT_W'(shifted - {1'b0, r_div});
                end else begin
                    r_rem <= shifted[CNT_W-1:0];
                end
                r_quo <= {r_quo[SUM_W-2:0], fits};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire
